// ----- hdl/crpre_pkg.sv -----
package crpre_pkg;

  localparam int FRAME_WIDTH  = 320;
  localparam int FRAME_HEIGHT = 240;
  localparam int PIX_COUNT    = FRAME_WIDTH * FRAME_HEIGHT;

  localparam int XW = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
  localparam int YW = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;
  localparam int AW = (PIX_COUNT > 1) ? $clog2(PIX_COUNT) : 1;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  localparam int COORD_W = 16;
  localparam int PIX_W   = 8;
  localparam int KIND_W  = 2;
  localparam int REG_W   = 2;

  localparam logic [KIND_W-1:0] KIND_PLOT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RECT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

  localparam logic [REG_W-1:0] REG_AND_MASK   = 2'd0;
  localparam logic [REG_W-1:0] REG_XOR_MASK   = 2'd1;
  localparam logic [REG_W-1:0] REG_SOLID_FILL = 2'd2;

  typedef enum logic [1:0] {
    OP_DRAW,
    OP_READ,
    OP_NOP
  } op_t;

  // Clipped command as the back end sees it.
  typedef struct packed {
    op_t           op;
    logic [XW-1:0] x_lo;
    logic [XW-1:0] x_hi;
    logic [XW-1:0] x1;
    logic [XW-1:0] x2;
    logic [YW-1:0] y_lo;
    logic [YW-1:0] y_hi;
    logic          span_ok;
    logic          row_ok;
    logic          hi_full;
    logic          x1_ok;
    logic          x2_ok;
  } desc_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ROW,
    ST_SPAN,
    ST_EDGE1,
    ST_EDGE2,
    ST_READ,
    ST_RWAIT,
    ST_DONE
  } st_t;

endpackage

// ----- hdl/crpre_front.sv -----
module crpre_front (
  input  logic                           in_valid,
  input  logic [crpre_pkg::KIND_W-1:0]   kind,
  input  logic [crpre_pkg::COORD_W-1:0]  x_first,
  input  logic [crpre_pkg::COORD_W-1:0]  y_first,
  input  logic [crpre_pkg::COORD_W-1:0]  x_second,
  input  logic [crpre_pkg::COORD_W-1:0]  y_second,
  input  logic                           q_full,
  input  logic                           clearing,
  output logic                           in_stall,
  output logic                           q_push,
  output crpre_pkg::desc_t               desc
);
  import crpre_pkg::*;

  logic [COORD_W-1:0] xmin, xmax, ymin, ymax;
  logic               x1_in, x2_in, y1_in;

  assign in_stall = q_full | clearing;
  assign q_push   = in_valid & ~in_stall;

  assign xmin  = (x_first < x_second) ? x_first : x_second;
  assign xmax  = (x_first < x_second) ? x_second : x_first;
  assign ymin  = (y_first < y_second) ? y_first : y_second;
  assign ymax  = (y_first < y_second) ? y_second : y_first;
  assign x1_in = x_first < COORD_W'(FRAME_WIDTH);
  assign x2_in = x_second < COORD_W'(FRAME_WIDTH);
  assign y1_in = y_first < COORD_W'(FRAME_HEIGHT);

  always_comb begin
    desc.op      = OP_NOP;
    desc.x1      = x_first[XW-1:0];
    desc.x2      = x_second[XW-1:0];
    desc.x1_ok   = x1_in;
    desc.x2_ok   = x2_in;
    desc.x_lo    = x_first[XW-1:0];
    desc.x_hi    = x_first[XW-1:0];
    desc.span_ok = x1_in;
    desc.y_lo    = y_first[YW-1:0];
    desc.y_hi    = y_first[YW-1:0];
    desc.row_ok  = y1_in;
    desc.hi_full = 1'b1;
    case (kind)
      KIND_PLOT: begin
        // a plot is a one-pixel full-span rectangle
        desc.op    = OP_DRAW;
        desc.x2_ok = 1'b0;
      end
      KIND_RECT: begin
        desc.op      = OP_DRAW;
        desc.x_lo    = xmin[XW-1:0];
        desc.x_hi    = (xmax < COORD_W'(FRAME_WIDTH)) ? xmax[XW-1:0] : XW'(FRAME_WIDTH - 1);
        desc.span_ok = xmin < COORD_W'(FRAME_WIDTH);
        desc.y_lo    = ymin[YW-1:0];
        desc.y_hi    = (ymax < COORD_W'(FRAME_HEIGHT)) ? ymax[YW-1:0] : YW'(FRAME_HEIGHT - 1);
        desc.row_ok  = ymin < COORD_W'(FRAME_HEIGHT);
        desc.hi_full = ymax < COORD_W'(FRAME_HEIGHT);
      end
      KIND_READ: begin
        desc.op = OP_READ;
      end
      default: begin
        desc.op = OP_NOP;
      end
    endcase
  end

endmodule

// ----- hdl/crpre_fifo.sv -----
module crpre_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  crpre_pkg::desc_t wdata,
  input  logic             pop,
  output crpre_pkg::desc_t rdata,
  output logic             full,
  output logic             empty
);
  import crpre_pkg::*;

  desc_t            entries [QDEPTH];
  logic [QAW-1:0]   wr_ptr, rd_ptr;
  logic [QAW:0]     count;
  logic             do_push, do_pop;

  assign full    = count == (QAW+1)'(QDEPTH);
  assign empty   = count == '0;
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= wdata;
  end

endmodule

// ----- hdl/crpre_back.sv -----
module crpre_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  input  crpre_pkg::desc_t              q_data,
  output logic                          q_pop,
  output logic                          clearing,
  input  logic [crpre_pkg::PIX_W-1:0]   and_mask,
  input  logic [crpre_pkg::PIX_W-1:0]   xor_mask,
  input  logic                          solid_fill,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [crpre_pkg::PIX_W-1:0]   read_data
);
  import crpre_pkg::*;

  st_t           st, st_next;
  desc_t         d, d_next;
  logic [XW-1:0] x_cur, x_next;
  logic [YW-1:0] y_cur, y_next;
  logic [AW-1:0] clr, clr_next;

  logic          row_full, last_row;
  st_t           adv_st;
  logic [YW-1:0] adv_y;

  logic          iss_vld, iss_rd;
  logic [XW-1:0] iss_x;
  logic [AW-1:0] iss_addr;
  logic          res_load;

  // pixel pipeline: issue reads the store, next stage modifies and writes back
  logic             p_vld, p_rd;
  logic [AW-1:0]    p_addr;
  logic [PIX_W-1:0] rdata;
  logic             w_vld;
  logic [AW-1:0]    w_addr;
  logic [PIX_W-1:0] w_data;
  logic [PIX_W-1:0] cur_pix, new_pix;
  logic [PIX_W-1:0] rd_val;
  logic [PIX_W-1:0] mem [PIX_COUNT];
  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  logic [PIX_W-1:0] mem_wd;

  assign clearing = st == ST_CLEAR;

  assign row_full = solid_fill || (y_cur == d.y_lo) || ((y_cur == d.y_hi) && d.hi_full);
  assign last_row = y_cur == d.y_hi;
  assign adv_st   = last_row ? ST_DONE : ST_ROW;
  assign adv_y    = last_row ? y_cur : y_cur + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= ST_CLEAR;
      clr <= '0;
    end else begin
      st  <= st_next;
      clr <= clr_next;
    end
    d     <= d_next;
    x_cur <= x_next;
    y_cur <= y_next;
  end

  always_comb begin
    st_next  = st;
    d_next   = d;
    x_next   = x_cur;
    y_next   = y_cur;
    clr_next = clr;
    q_pop    = 1'b0;
    iss_vld  = 1'b0;
    iss_rd   = 1'b0;
    iss_x    = x_cur;
    res_load = 1'b0;
    case (st)
      ST_CLEAR: begin
        clr_next = clr + 1'b1;
        if (clr == AW'(PIX_COUNT - 1)) st_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop  = 1'b1;
          d_next = q_data;
          y_next = q_data.y_lo;
          case (q_data.op)
            OP_DRAW: st_next = q_data.row_ok ? ST_ROW : ST_DONE;
            OP_READ: st_next = (q_data.row_ok && q_data.x1_ok) ? ST_READ : ST_DONE;
            default: st_next = ST_DONE;
          endcase
        end
      end
      ST_ROW: begin
        if (!row_full) begin
          st_next = ST_EDGE1;
        end else if (d.span_ok) begin
          st_next = ST_SPAN;
          x_next  = d.x_lo;
        end else begin
          st_next = adv_st;
          y_next  = adv_y;
        end
      end
      ST_SPAN: begin
        iss_vld = 1'b1;
        if (x_cur == d.x_hi) begin
          st_next = adv_st;
          y_next  = adv_y;
        end else begin
          x_next = x_cur + 1'b1;
        end
      end
      ST_EDGE1: begin
        iss_vld = d.x1_ok;
        iss_x   = d.x1;
        st_next = ST_EDGE2;
      end
      ST_EDGE2: begin
        // same pixel again when both x are equal
        iss_vld = d.x2_ok;
        iss_x   = d.x2;
        st_next = adv_st;
        y_next  = adv_y;
      end
      ST_READ: begin
        iss_vld = 1'b1;
        iss_rd  = 1'b1;
        iss_x   = d.x1;
        st_next = ST_RWAIT;
      end
      ST_RWAIT: begin
        st_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          res_load = 1'b1;
          st_next  = ST_IDLE;
        end
      end
      default: begin
        st_next = ST_IDLE;
      end
    endcase
  end

  assign iss_addr = AW'(y_cur) * AW'(FRAME_WIDTH) + AW'(iss_x);

  // forward the previous write when a read hit the address being written
  assign cur_pix = (w_vld && (w_addr == p_addr)) ? w_data : rdata;
  assign new_pix = (cur_pix & and_mask) ^ xor_mask;

  assign mem_we = clearing | (p_vld & ~p_rd);
  assign mem_wa = clearing ? clr : p_addr;
  assign mem_wd = clearing ? '0 : new_pix;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata <= mem[iss_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
      w_vld <= 1'b0;
    end else begin
      p_vld <= iss_vld;
      w_vld <= p_vld & ~p_rd;
    end
    p_rd   <= iss_rd;
    p_addr <= iss_addr;
    w_addr <= p_addr;
    w_data <= new_pix;
    if (q_pop) rd_val <= '0;
    else if (p_vld && p_rd) rd_val <= cur_pix;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (res_load) read_data <= (d.op == OP_READ) ? rd_val : '0;
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("pop from empty queue");

  a_no_issue_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (!iss_vld && !q_pop))
    else $error("work started during clearing pass");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(st == ST_DONE))
    else $error("result raised outside done state");

  a_read_in_flight: assert property (@(posedge clk) disable iff (rst)
    (st == ST_RWAIT) |-> (p_vld && p_rd))
    else $error("read wait without read in pipeline");

endmodule

// ----- hdl/clipped_rectangle_pixel_rop_engine_top.sv -----
// Drawing: full rows issue one pixel per cycle; an outline side row issues
//   its edge pixels from ST_EDGE1 (x1) and ST_EDGE2 (x2), each if inside the frame.
// Throughput: one item at a time in the back end; a 4-entry queue lets the
//   front accept while a command draws. The result register holds until taken.
// Reset: synchronous, active high. After reset a clearing pass writes zero to
//   all 76800 store entries, one per cycle; no item is accepted until it ends.
module clipped_rectangle_pixel_rop_engine_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [crpre_pkg::REG_W-1:0]    cfg_index,
  input  logic [crpre_pkg::PIX_W-1:0]    cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [crpre_pkg::KIND_W-1:0]   kind,
  input  logic [crpre_pkg::COORD_W-1:0]  x_first,
  input  logic [crpre_pkg::COORD_W-1:0]  y_first,
  input  logic [crpre_pkg::COORD_W-1:0]  x_second,
  input  logic [crpre_pkg::COORD_W-1:0]  y_second,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [crpre_pkg::PIX_W-1:0]    read_data
);
  import crpre_pkg::*;

  logic [PIX_W-1:0] and_mask, xor_mask;
  logic             solid_fill;
  logic             q_push, q_pop, q_full, q_empty, clearing;
  desc_t            q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      and_mask   <= 8'd0;
      xor_mask   <= 8'd7;
      solid_fill <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_AND_MASK:   and_mask   <= cfg_data;
        REG_XOR_MASK:   xor_mask   <= cfg_data;
        REG_SOLID_FILL: solid_fill <= cfg_data[0];
        default: ;
      endcase
    end
  end

  crpre_front u_front (
    .in_valid (in_valid),
    .kind     (kind),
    .x_first  (x_first),
    .y_first  (y_first),
    .x_second (x_second),
    .y_second (y_second),
    .q_full   (q_full),
    .clearing (clearing),
    .in_stall (in_stall),
    .q_push   (q_push),
    .desc     (q_wdata)
  );

  crpre_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  crpre_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_data     (q_rdata),
    .q_pop      (q_pop),
    .clearing   (clearing),
    .and_mask   (and_mask),
    .xor_mask   (xor_mask),
    .solid_fill (solid_fill),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .read_data  (read_data)
  );

endmodule

// ----- tb/clipped_rectangle_pixel_rop_engine_top_tb.sv -----
module clipped_rectangle_pixel_rop_engine_top_tb;
  import crpre_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam logic [REG_W-1:0]  REG_SPARE  = 2'd3;

  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic [COORD_W-1:0] xa;
    logic [COORD_W-1:0] ya;
    logic [COORD_W-1:0] xb;
    logic [COORD_W-1:0] yb;
  } draw_cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               cfg_write = 1'b0;
  logic [REG_W-1:0]   cfg_index = '0;
  logic [PIX_W-1:0]   cfg_data  = '0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [KIND_W-1:0]  kind      = '0;
  logic [COORD_W-1:0] x_first   = '0;
  logic [COORD_W-1:0] y_first   = '0;
  logic [COORD_W-1:0] x_second  = '0;
  logic [COORD_W-1:0] y_second  = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [PIX_W-1:0]   read_data;

  // Shadow frame store and register copies
  logic [PIX_W-1:0] frame_model [0:PIX_COUNT-1];
  logic [PIX_W-1:0] and_m;
  logic [PIX_W-1:0] xor_m;
  logic             fill_m;

  draw_cmd_t        pending_cmds[$];
  logic [PIX_W-1:0] expected_read_data[$];
  int               n_queued   = 0;
  int               n_accepted = 0;
  int               failures   = 0;
  int               send_idle_pct  = 0;
  int               recv_stall_pct = 0;

  clipped_rectangle_pixel_rop_engine_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .x_first   (x_first),
    .y_first   (y_first),
    .x_second  (x_second),
    .y_second  (y_second),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .read_data (read_data)
  );

  always #10 clk = ~clk;

  function automatic void rop_pixel(int unsigned x, int unsigned y);
    int unsigned a;
    if (x < FRAME_WIDTH && y < FRAME_HEIGHT) begin
      a = y * FRAME_WIDTH + x;
      frame_model[a] = (frame_model[a] & and_m) ^ xor_m;
    end
  endfunction

  function automatic void rop_span(int unsigned xa, int unsigned xb, int unsigned y);
    int unsigned lo;
    int unsigned hi;
    lo = (xa < xb) ? xa : xb;
    hi = (xa < xb) ? xb : xa;
    if (y >= FRAME_HEIGHT || lo >= FRAME_WIDTH) return;
    if (hi >= FRAME_WIDTH) hi = FRAME_WIDTH - 1;
    for (int unsigned x = lo; x <= hi; x++) rop_pixel(x, y);
  endfunction

  function automatic void rop_rect(int unsigned x1, int unsigned y1,
                                   int unsigned x2, int unsigned y2);
    int unsigned lo;
    int unsigned hi;
    lo = (y1 < y2) ? y1 : y2;
    hi = (y1 < y2) ? y2 : y1;
    if (lo >= FRAME_HEIGHT) return;
    if (hi >= FRAME_HEIGHT) hi = FRAME_HEIGHT - 1;
    for (int unsigned y = lo; y <= hi; y++) begin
      if (fill_m || y == y1 || y == y2) begin
        rop_span(x1, x2, y);
      end else begin
        // outline side edges; equal x hits the same pixel twice
        rop_pixel(x1, y);
        rop_pixel(x2, y);
      end
    end
  endfunction

  function automatic logic [PIX_W-1:0] apply_command(
      logic [KIND_W-1:0] k, logic [COORD_W-1:0] xa, logic [COORD_W-1:0] ya,
      logic [COORD_W-1:0] xb, logic [COORD_W-1:0] yb);
    logic [PIX_W-1:0] data;
    data = '0;
    case (k)
      KIND_PLOT: rop_pixel(32'(xa), 32'(ya));
      KIND_RECT: rop_rect(32'(xa), 32'(ya), 32'(xb), 32'(yb));
      KIND_READ: begin
        if (xa < FRAME_WIDTH && ya < FRAME_HEIGHT)
          data = frame_model[int'(ya) * FRAME_WIDTH + int'(xa)];
      end
      default: ;
    endcase
    return data;
  endfunction

  // Mostly near the origin or straddling the far border so reads hit drawn pixels.
  function automatic logic [COORD_W-1:0] pick_coord(int lim);
    int v;
    case ($urandom_range(9))
      0:          v = $urandom_range(65535);
      1:          v = lim - 1 + int'($urandom_range(1));
      2, 3, 4, 5: v = $urandom_range(23);
      default:    v = lim - 24 + int'($urandom_range(31));
    endcase
    return v[COORD_W-1:0];
  endfunction

  function automatic logic [COORD_W-1:0] near_coord(logic [COORD_W-1:0] c);
    int t;
    t = int'(c) + int'($urandom_range(24)) - 12;
    if (t < 0) t = 0;
    return t[COORD_W-1:0];
  endfunction

  function automatic draw_cmd_t random_cmd();
    draw_cmd_t c;
    int sel;
    sel = $urandom_range(99);
    if (sel < 30)      c.kind = KIND_PLOT;
    else if (sel < 62) c.kind = KIND_RECT;
    else if (sel < 95) c.kind = KIND_READ;
    else               c.kind = KIND_SPARE;
    c.xa = pick_coord(FRAME_WIDTH);
    c.ya = pick_coord(FRAME_HEIGHT);
    c.xb = COORD_W'($urandom_range(65535));
    c.yb = COORD_W'($urandom_range(65535));
    if (c.kind == KIND_RECT) begin
      // small rectangles, now and then one wide side (never both)
      case ($urandom_range(7))
        0: c.yb = near_coord(c.ya);
        1: c.xb = near_coord(c.xa);
        default: begin
          c.xb = near_coord(c.xa);
          c.yb = near_coord(c.ya);
        end
      endcase
    end
    return c;
  endfunction

  task automatic queue_cmd(logic [KIND_W-1:0] k, int xa, int ya, int xb, int yb);
    draw_cmd_t c;
    c.kind = k;
    c.xa = xa[COORD_W-1:0];
    c.ya = ya[COORD_W-1:0];
    c.xb = xb[COORD_W-1:0];
    c.yb = yb[COORD_W-1:0];
    pending_cmds.push_back(c);
    n_queued++;
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (!(n_accepted == n_queued && expected_read_data.size() == 0));
    repeat (10) @(posedge clk);
  endtask

  task automatic set_reg(logic [REG_W-1:0] idx, logic [PIX_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_AND_MASK:   and_m  = val;
      REG_XOR_MASK:   xor_m  = val;
      REG_SOLID_FILL: fill_m = val[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_regs(logic [PIX_W-1:0] a, logic [PIX_W-1:0] x, logic f);
    set_reg(REG_AND_MASK, a);
    set_reg(REG_XOR_MASK, x);
    set_reg(REG_SOLID_FILL, {7'($urandom_range(127)), f});
  endtask

  task automatic random_batch(int n, int idle_pct, int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) begin
      pending_cmds.push_back(random_cmd());
      n_queued++;
    end
    wait_drained();
  endtask

  // Driver: one item at a time, held until accepted
  always @(posedge clk) begin : drive
    draw_cmd_t c;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_read_data.push_back(
          apply_command(kind, x_first, y_first, x_second, y_second));
        n_accepted++;
      end
      if (!(in_valid && in_stall)) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          c = pending_cmds.pop_front();
          in_valid <= 1'b1;
          kind     <= c.kind;
          x_first  <= c.xa;
          y_first  <= c.ya;
          x_second <= c.xb;
          y_second <= c.yb;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: every command completes with one result item
  always @(posedge clk) begin : monitor
    logic [PIX_W-1:0] exp_data;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_read_data.size() == 0) begin
          $error("read_data: no item expected, got %0h", read_data);
          failures++;
        end else begin
          exp_data = expected_read_data.pop_front();
          if (read_data !== exp_data) begin
            $error("read_data mismatch: expected %0h, got %0h", exp_data, read_data);
            failures++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    for (int i = 0; i < PIX_COUNT; i++) frame_model[i] = '0;
    and_m  = 8'h00;
    xor_m  = 8'h07;
    fill_m = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset register values, cleared store
    queue_cmd(KIND_READ, 0, 0, 65535, 65535);
    queue_cmd(KIND_PLOT, 0, 0, 0, 0);
    queue_cmd(KIND_READ, 0, 0, 0, 0);
    queue_cmd(KIND_PLOT, FRAME_WIDTH - 1, FRAME_HEIGHT - 1, 0, 0);
    queue_cmd(KIND_READ, FRAME_WIDTH - 1, FRAME_HEIGHT - 1, 0, 0);
    queue_cmd(KIND_PLOT, FRAME_WIDTH, 5, 0, 0);
    queue_cmd(KIND_PLOT, 5, FRAME_HEIGHT, 0, 0);
    queue_cmd(KIND_READ, FRAME_WIDTH, 5, 0, 0);
    queue_cmd(KIND_READ, 0, 6, 0, 0);       // would alias x = width on row 5
    queue_cmd(KIND_READ, 65535, 65535, 0, 0);
    queue_cmd(KIND_RECT, 14, 25, 10, 20);
    queue_cmd(KIND_READ, 12, 22, 0, 0);
    queue_cmd(KIND_READ, 10, 22, 0, 0);
    queue_cmd(KIND_READ, 12, 25, 0, 0);
    queue_cmd(KIND_SPARE, 65535, 65535, 65535, 65535);
    wait_drained();

    set_regs(8'hff, 8'h5a, 1'b0);
    set_reg(REG_SPARE, 8'hff);
    queue_cmd(KIND_RECT, 5, 30, 5, 34);     // equal x: middle rows toggle back
    queue_cmd(KIND_READ, 5, 32, 0, 0);
    queue_cmd(KIND_READ, 5, 30, 0, 0);
    queue_cmd(KIND_RECT, 65535, 50, 0, 50); // single row
    queue_cmd(KIND_READ, FRAME_WIDTH - 1, 50, 0, 0);
    queue_cmd(KIND_RECT, 65535, 65535, 0, 0);
    queue_cmd(KIND_READ, 0, 100, 0, 0);
    queue_cmd(KIND_READ, 100, 100, 0, 0);
    wait_drained();

    set_regs(8'h00, 8'hff, 1'b1);
    queue_cmd(KIND_RECT, 0, 0, 65535, 65535);
    queue_cmd(KIND_READ, 160, 120, 0, 0);
    wait_drained();

    set_regs(PIX_W'($urandom_range(255)), PIX_W'($urandom_range(255)), 1'b0);
    random_batch(76, 0, 0);
    set_regs(8'hff, 8'hff, 1'b1);
    random_batch(76, 78, 0);
    set_regs(PIX_W'($urandom_range(255)), PIX_W'($urandom_range(255)), 1'b1);
    random_batch(76, 0, 78);
    set_regs(8'h00, PIX_W'($urandom_range(255)), 1'b0);
    random_batch(76, 20, 20);
    set_regs(8'hff, 8'h00, 1'($urandom_range(1)));
    random_batch(76, 0, 0);

    repeat (100) @(posedge clk);
    if (failures == 0) begin
      $display("clipped_rectangle_pixel_rop_engine_top_tb OK");
    end else begin
      $display("clipped_rectangle_pixel_rop_engine_top_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("clipped_rectangle_pixel_rop_engine_top_tb NOT OK");
    $finish;
  end

endmodule
